@@ sv/joint_residual_decay_filter_macros.svh @@
// Assertion shorthands used by the checker file.
`ifndef JOINT_RESIDUAL_DECAY_FILTER_MACROS_SVH
`define JOINT_RESIDUAL_DECAY_FILTER_MACROS_SVH

// property checked at every rising clock edge outside reset
`define JRDF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("jrdf assertion failed");

// antecedent in one cycle implies consequent in the next
`define JRDF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("jrdf assertion failed");

`endif

@@ sv/jrdf_pkg.sv @@
package jrdf_pkg;

  localparam int unsigned JointW   = 4;
  localparam int unsigned DataW    = 32;
  localparam int unsigned FracW    = 16;
  localparam int unsigned ProdW    = 2 * DataW - FracW;
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  typedef logic signed [DataW-1:0] q_t;

  localparam q_t QOne = q_t'(1 << FracW);

  typedef enum logic [0:0] {
    OP_LOAD   = 1'b0,
    OP_UPDATE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    REG_COEF_PP    = 3'd0,
    REG_COEF_PV    = 3'd1,
    REG_COEF_VP    = 3'd2,
    REG_COEF_VV    = 3'd3,
    REG_CONFIGURED = 3'd4
  } reg_idx_e;

  typedef struct packed {
    q_t pp;
    q_t pv;
    q_t vp;
    q_t vv;
  } coef_t;

  // clamp a sign-extended wide value into Q16.16
  function automatic q_t sat_wide(input logic signed [ProdW:0] v);
    logic [ProdW-DataW+1:0] top;
    top = v[ProdW:DataW-1];
    if (top == '0 || top == '1) begin
      return q_t'(v[DataW-1:0]);
    end else if (v[ProdW]) begin
      return q_t'({1'b1, {(DataW-1){1'b0}}});
    end else begin
      return q_t'({1'b0, {(DataW-1){1'b1}}});
    end
  endfunction

  function automatic q_t sat_add(input q_t a, input q_t b);
    logic signed [DataW:0] s;
    s = {a[DataW-1], a} + {b[DataW-1], b};
    return sat_wide({{(ProdW-DataW){s[DataW]}}, s});
  endfunction

  function automatic q_t sat_sub(input q_t a, input q_t b);
    logic signed [DataW:0] s;
    s = {a[DataW-1], a} - {b[DataW-1], b};
    return sat_wide({{(ProdW-DataW){s[DataW]}}, s});
  endfunction

endpackage

@@ sv/jrdf_if.sv @@
interface jrdf_in_if;
  import jrdf_pkg::*;

  logic              valid;
  logic              ready;
  op_e               opcode;
  logic [JointW-1:0] joint;
  q_t                position_in;
  q_t                velocity_in;

  modport source (output valid, opcode, joint, position_in, velocity_in, input ready);
  modport sink   (input valid, opcode, joint, position_in, velocity_in, output ready);
endinterface

interface jrdf_out_if;
  import jrdf_pkg::*;

  logic              valid;
  logic              ready;
  logic [JointW-1:0] joint_out;
  q_t                position_out;
  q_t                velocity_out;
  logic              ok;

  modport source (output valid, joint_out, position_out, velocity_out, ok, input ready);
  modport sink   (input valid, joint_out, position_out, velocity_out, ok, output ready);
endinterface

@@ sv/jrdf_mac.sv @@
// 2x2 matrix times residual: registered truncated products, then saturated sums.
module jrdf_mac (
  input  logic            clk_i,
  input  logic            en_i,
  input  jrdf_pkg::q_t    rp_i,
  input  jrdf_pkg::q_t    rv_i,
  input  jrdf_pkg::coef_t coef_i,
  output jrdf_pkg::q_t    np_o,
  output jrdf_pkg::q_t    nv_o
);
  import jrdf_pkg::*;

  typedef logic signed [ProdW-1:0] prod_t;

  logic signed [2*DataW-1:0] m_pp, m_pv, m_vp, m_vv;
  prod_t pp_q, pv_q, vp_q, vv_q;
  logic signed [ProdW:0] sum_p, sum_v;

  assign m_pp = $signed(coef_i.pp) * $signed(rp_i);
  assign m_pv = $signed(coef_i.pv) * $signed(rv_i);
  assign m_vp = $signed(coef_i.vp) * $signed(rp_i);
  assign m_vv = $signed(coef_i.vv) * $signed(rv_i);

  // dropping the low fraction bits is an arithmetic shift: floor rounding
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q <= m_pp[2*DataW-1:FracW];
      pv_q <= m_pv[2*DataW-1:FracW];
      vp_q <= m_vp[2*DataW-1:FracW];
      vv_q <= m_vv[2*DataW-1:FracW];
    end
  end

  assign sum_p = {pp_q[ProdW-1], pp_q} + {pv_q[ProdW-1], pv_q};
  assign sum_v = {vp_q[ProdW-1], vp_q} + {vv_q[ProdW-1], vv_q};

  assign np_o = sat_wide(sum_p);
  assign nv_o = sat_wide(sum_v);

endmodule

@@ sv/joint_residual_decay_filter.sv @@
// Channel  Direction  Handshake        Word
// in_i     in         valid/ready      opcode, joint, position_in, velocity_in
// out_o    out        valid/ready      joint_out, position_out, velocity_out, ok
// APB      in         psel/penable     four coefficients, configured flag
//
// One word per cycle unless stalled; an update word passes stages 1 to 4 and the output register.
// The state memory is read at accept and written as the word leaves stage 3, so a word stalls
// at the input while an earlier word of the same joint is in stages 1 to 3.
// Reset loads identity coefficients, clears configured and per-entry valid bits; no clearing pass.
// Output backpressure holds only full stages; bubbles close up behind it.
module joint_residual_decay_filter #(
  parameter int unsigned NUM_JOINTS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  jrdf_in_if.sink                        in_i,
  jrdf_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [jrdf_pkg::ApbAddrW-1:0]  paddr,
  input  logic [jrdf_pkg::ApbDataW-1:0]  pwdata,
  output logic [jrdf_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);
  import jrdf_pkg::*;

  localparam int unsigned IdxW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  typedef struct packed {
    logic pend;
    q_t   rp;
    q_t   rv;
  } ent_t;

  // ---------------- configuration ----------------
  coef_t    coef_q;
  logic     configured_q;
  logic     cfg_we;
  reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[ApbAddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q       <= '{pp: QOne, pv: '0, vp: '0, vv: QOne};
      configured_q <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_COEF_PP:    coef_q.pp    <= q_t'(pwdata);
        REG_COEF_PV:    coef_q.pv    <= q_t'(pwdata);
        REG_COEF_VP:    coef_q.vp    <= q_t'(pwdata);
        REG_COEF_VV:    coef_q.vv    <= q_t'(pwdata);
        REG_CONFIGURED: configured_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_COEF_PP:    prdata = ApbDataW'(coef_q.pp);
      REG_COEF_PV:    prdata = ApbDataW'(coef_q.pv);
      REG_COEF_VP:    prdata = ApbDataW'(coef_q.vp);
      REG_COEF_VV:    prdata = ApbDataW'(coef_q.vv);
      REG_CONFIGURED: prdata = ApbDataW'(configured_q);
      default:        prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic en1, en2, en3, en4, en_o;
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic acc, hazard, in_range, is_load;
  logic [JointW-1:0] s1_joint_q, s2_joint_q, s3_joint_q, s4_joint_q;

  assign en_o = !out_v_q || out_o.ready;
  assign en4  = !s4_v_q || en_o;
  assign en3  = !s3_v_q || en4;
  assign en2  = !s2_v_q || en3;
  assign en1  = !s1_v_q || en2;

  // an entry is in flight from its read until its write in stage 3
  assign hazard = (s1_v_q && s1_joint_q == in_i.joint) ||
                  (s2_v_q && s2_joint_q == in_i.joint) ||
                  (s3_v_q && s3_joint_q == in_i.joint);

  assign in_i.ready = en1 && !hazard;
  assign acc        = in_i.valid && in_i.ready;
  assign in_range   = 32'(in_i.joint) < NUM_JOINTS;
  assign is_load    = (in_i.opcode == OP_LOAD);

  // ---------------- state memory ----------------
  ent_t                  mem [NUM_JOINTS];
  ent_t                  rd_q;
  logic [NUM_JOINTS-1:0] valid_q;
  logic [IdxW-1:0]       rd_idx, wr_idx;
  logic                  mem_we;
  ent_t                  wr_data;

  assign rd_idx = IdxW'(in_i.joint);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_idx] <= wr_data;
    end
    if (acc) begin
      rd_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (mem_we) begin
      valid_q[wr_idx] <= 1'b1;
    end
  end

  // ---------------- stage 1: memory data ----------------
  logic s1_load_q, s1_we_q, s1_ok_q, s1_hit_q;
  q_t   s1_pin_q, s1_vin_q;
  ent_t cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en1) begin
      s1_v_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_load_q  <= is_load;
      s1_we_q    <= in_range && (is_load || configured_q);
      s1_ok_q    <= in_range && !is_load && configured_q;
      s1_joint_q <= in_i.joint;
      s1_pin_q   <= in_i.position_in;
      s1_vin_q   <= in_i.velocity_in;
      s1_hit_q   <= valid_q[rd_idx];
    end
  end

  // never-written entries read as the reset value
  assign cur = s1_hit_q ? rd_q : '0;

  // ---------------- stage 2: first-update correction ----------------
  logic s2_load_q, s2_we_q, s2_ok_q;
  q_t   s2_pin_q, s2_vin_q, s2_rp_q, s2_rv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en2) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_load_q  <= s1_load_q;
      s2_we_q    <= s1_we_q;
      s2_ok_q    <= s1_ok_q;
      s2_joint_q <= s1_joint_q;
      s2_pin_q   <= s1_pin_q;
      s2_vin_q   <= s1_vin_q;
      s2_rp_q    <= cur.pend ? sat_sub(cur.rp, s1_pin_q) : cur.rp;
      s2_rv_q    <= cur.pend ? sat_sub(cur.rv, s1_vin_q) : cur.rv;
    end
  end

  // ---------------- stage 3: products, sums, write-back ----------------
  logic s3_load_q, s3_we_q, s3_ok_q;
  q_t   s3_pin_q, s3_vin_q, np, nv;

  jrdf_mac u_mac (
    .clk_i  (clk_i),
    .en_i   (en3),
    .rp_i   (s2_rp_q),
    .rv_i   (s2_rv_q),
    .coef_i (coef_q),
    .np_o   (np),
    .nv_o   (nv)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en3) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_load_q  <= s2_load_q;
      s3_we_q    <= s2_we_q;
      s3_ok_q    <= s2_ok_q;
      s3_joint_q <= s2_joint_q;
      s3_pin_q   <= s2_pin_q;
      s3_vin_q   <= s2_vin_q;
    end
  end

  // write when the word leaves stage 3
  assign mem_we  = s3_v_q && s3_we_q && en4;
  assign wr_idx  = IdxW'(s3_joint_q);
  assign wr_data = s3_load_q ? ent_t'{pend: 1'b1, rp: s3_pin_q, rv: s3_vin_q}
                             : ent_t'{pend: 1'b0, rp: np, rv: nv};

  // ---------------- stage 4: reference and new residual ----------------
  logic s4_ok_q;
  q_t   s4_pin_q, s4_vin_q, s4_np_q, s4_nv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en4) begin
      s4_v_q <= s3_v_q && !s3_load_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_ok_q    <= s3_ok_q;
      s4_joint_q <= s3_joint_q;
      s4_pin_q   <= s3_pin_q;
      s4_vin_q   <= s3_vin_q;
      s4_np_q    <= np;
      s4_nv_q    <= nv;
    end
  end

  // ---------------- output register ----------------
  logic [JointW-1:0] out_joint_q;
  q_t                out_pos_q, out_vel_q;
  logic              out_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_o) begin
      out_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      out_joint_q <= s4_joint_q;
      out_ok_q    <= s4_ok_q;
      out_pos_q   <= s4_ok_q ? sat_add(s4_pin_q, s4_np_q) : '0;
      out_vel_q   <= s4_ok_q ? sat_add(s4_vin_q, s4_nv_q) : '0;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.joint_out    = out_joint_q;
  assign out_o.position_out = out_pos_q;
  assign out_o.velocity_out = out_vel_q;
  assign out_o.ok           = out_ok_q;

endmodule

@@ sv/jrdf_checker.sv @@
`include "joint_residual_decay_filter_macros.svh"

module jrdf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [jrdf_pkg::JointW-1:0] in_joint,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [jrdf_pkg::JointW-1:0] out_joint,
  input jrdf_pkg::q_t                out_pos,
  input jrdf_pkg::q_t                out_vel,
  input logic                        out_ok,
  input logic                        pready
);
  import jrdf_pkg::*;

  `JRDF_ASSERT(a_pready_high, clk_i, rst_ni, pready)

  `JRDF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_pos) && $stable(out_vel) && $stable(out_ok) && $stable(out_joint))

  // a refused update carries zero values
  `JRDF_ASSERT(a_refused_zero, clk_i, rst_ni, (out_valid && !out_ok) |-> (out_pos == '0 && out_vel == '0))

  // read-modify-write interlock: a joint cannot be taken twice in a row
  `JRDF_ASSERT_NEXT(a_same_joint_gap, clk_i, rst_ni, in_valid && in_ready, !(in_valid && in_ready && in_joint == $past(in_joint)))

endmodule

bind joint_residual_decay_filter jrdf_checker u_jrdf_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_joint  (in_i.joint),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_joint (out_o.joint_out),
  .out_pos   (out_o.position_out),
  .out_vel   (out_o.velocity_out),
  .out_ok    (out_o.ok),
  .pready    (pready)
);

@@ tb/joint_residual_decay_filter_test.sv @@
module joint_residual_decay_filter_test;
  import jrdf_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int NUM_JOINTS    = 16;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_CYCLES    = 500000;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_WORDS   = 250;
  localparam int NUM_DIR       = 18;
  localparam int DIR_CFG_AT    = 4;

  localparam q_t QMAX = 32'sh7fffffff;
  localparam q_t QMIN = 32'sh80000000;

  typedef struct packed {
    op_e               op;
    logic [JointW-1:0] joint;
    q_t                pos;
    q_t                vel;
  } word_t;

  typedef struct packed {
    logic [JointW-1:0] joint;
    q_t                pos;
    q_t                vel;
    logic              ok;
  } result_t;

  typedef struct packed {
    word_t   w;
    logic    typed;
    result_t res;
  } dir_row_t;

  // rows before DIR_CFG_AT run unconfigured, the rest with the identity matrix
  localparam dir_row_t DIR_TAB [NUM_DIR] = '{
    '{'{OP_UPDATE, 4'd0,  32'sh12345678, -32'sd1}, 1'b1, '{4'd0, 32'sd0, 32'sd0, 1'b0}},
    '{'{OP_LOAD,   4'd15, QMAX, QMIN},             1'b0, '0},
    '{'{OP_UPDATE, 4'd15, QMIN, QMAX},             1'b1, '{4'd15, 32'sd0, 32'sd0, 1'b0}},
    '{'{OP_UPDATE, 4'd7,  QMAX, QMAX},             1'b1, '{4'd7, 32'sd0, 32'sd0, 1'b0}},
    // joint 15 still pending from the refused update
    '{'{OP_UPDATE, 4'd15, 32'sd0, 32'sd0},         1'b1, '{4'd15, QMAX, QMIN, 1'b1}},
    '{'{OP_UPDATE, 4'd15, 32'sd1, 32'sd1},         1'b1, '{4'd15, QMAX, 32'sh80000001, 1'b1}},
    // never loaded: tracks the reference
    '{'{OP_UPDATE, 4'd3,  32'sd100, -32'sd100},    1'b1, '{4'd3, 32'sd100, -32'sd100, 1'b1}},
    '{'{OP_LOAD,   4'd3,  QMAX, QMIN},             1'b0, '0},
    '{'{OP_UPDATE, 4'd3,  QMIN, QMAX},             1'b1, '{4'd3, -32'sd1, -32'sd1, 1'b1}},
    '{'{OP_LOAD,   4'd4,  32'sh00050000, 32'sd0},  1'b0, '0},
    '{'{OP_UPDATE, 4'd4,  32'sh00020000, 32'sd0},  1'b1,
      '{4'd4, 32'sh00050000, 32'sd0, 1'b1}},
    '{'{OP_UPDATE, 4'd4,  32'sd0, 32'sd0},         1'b1, '{4'd4, 32'sh00030000, 32'sd0, 1'b1}},
    '{'{OP_LOAD,   4'd5,  -32'sd1, -32'sd1},       1'b0, '0},
    '{'{OP_UPDATE, 4'd5,  32'sd0, 32'sd0},         1'b1, '{4'd5, -32'sd1, -32'sd1, 1'b1}},
    '{'{OP_UPDATE, 4'd5,  32'sh7fff0000, 32'sh80010000}, 1'b0, '0},
    '{'{OP_UPDATE, 4'd0,  QMAX, QMIN},             1'b0, '0},
    '{'{OP_LOAD,   4'd0,  32'sh0000ffff, 32'shffff0000}, 1'b0, '0},
    '{'{OP_UPDATE, 4'd0,  32'shaaaaaaaa, 32'sh55555555}, 1'b0, '0}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  jrdf_in_if  in_if ();
  jrdf_out_if out_if ();

  joint_residual_decay_filter #(
    .NUM_JOINTS(NUM_JOINTS)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // filter state as the block should hold it
  q_t   coef_pp = QOne;
  q_t   coef_pv = '0;
  q_t   coef_vp = '0;
  q_t   coef_vv = QOne;
  logic cfg_on  = 1'b0;
  q_t   res_pos    [NUM_JOINTS] = '{default: '0};
  q_t   res_vel    [NUM_JOINTS] = '{default: '0};
  logic first_pend [NUM_JOINTS] = '{default: 1'b0};

  result_t filter_out_q[$];
  int      bad_words = 0;
  int      cycle_cnt = 0;
  logic    calm = 1'b0;

  function automatic q_t clamp_q(input longint v);
    if (v > longint'(QMAX)) return QMAX;
    if (v < longint'(QMIN)) return QMIN;
    return q_t'(v);
  endfunction

  // Q16.16 product, arithmetic shift rounds toward minus infinity
  function automatic longint qprod(input q_t a, input q_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> FracW;
  endfunction

  function automatic logic decay_step(input word_t w, output result_t r);
    q_t rp;
    q_t rv;
    r = '{joint: w.joint, pos: '0, vel: '0, ok: 1'b0};
    if (w.op == OP_LOAD) begin
      res_pos[w.joint]    = w.pos;
      res_vel[w.joint]    = w.vel;
      first_pend[w.joint] = 1'b1;
      return 1'b0;
    end
    if (!cfg_on) return 1'b1;
    if (first_pend[w.joint]) begin
      res_pos[w.joint]    = clamp_q(longint'(res_pos[w.joint]) - longint'(w.pos));
      res_vel[w.joint]    = clamp_q(longint'(res_vel[w.joint]) - longint'(w.vel));
      first_pend[w.joint] = 1'b0;
    end
    rp = res_pos[w.joint];
    rv = res_vel[w.joint];
    res_pos[w.joint] = clamp_q(qprod(coef_pp, rp) + qprod(coef_pv, rv));
    res_vel[w.joint] = clamp_q(qprod(coef_vp, rp) + qprod(coef_vv, rv));
    r.pos = clamp_q(longint'(w.pos) + longint'(res_pos[w.joint]));
    r.vel = clamp_q(longint'(w.vel) + longint'(res_vel[w.joint]));
    r.ok  = 1'b1;
    return 1'b1;
  endfunction

  function automatic q_t rand_q();
    case ($urandom_range(0, 9))
      0:       return QMIN;
      1:       return QMAX;
      2:       return '0;
      3, 4:    return q_t'($urandom_range(0, 32'h0010_0000)) - q_t'(32'h0008_0000);
      default: return q_t'($urandom);
    endcase
  endfunction

  // a quarter of the picks crowd onto two joints to hit the same-joint hazard
  function automatic logic [JointW-1:0] pick_joint();
    if ($urandom_range(0, 3) == 0) return JointW'($urandom_range(0, 1));
    return JointW'($urandom_range(0, NUM_JOINTS - 1));
  endfunction

  // called right after a rising edge; returns right after the access edge
  task automatic apb_write(input reg_idx_e idx, input logic [ApbDataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_COEF_PP:    coef_pp = q_t'(val);
      REG_COEF_PV:    coef_pv = q_t'(val);
      REG_COEF_VP:    coef_vp = q_t'(val);
      REG_COEF_VV:    coef_vv = q_t'(val);
      REG_CONFIGURED: cfg_on  = val[0];
      default: ;
    endcase
  endtask

  task automatic set_coefs(input q_t pp, input q_t pv, input q_t vp, input q_t vv,
                           input logic on);
    apb_write(REG_COEF_PP, pp);
    apb_write(REG_COEF_PV, pv);
    apb_write(REG_COEF_VP, vp);
    apb_write(REG_COEF_VV, vv);
    apb_write(REG_CONFIGURED, {{(ApbDataW-1){1'b0}}, on});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic push_word(input word_t w, input logic typed, input result_t typed_res);
    result_t r;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.opcode      <= w.op;
    in_if.joint       <= w.joint;
    in_if.position_in <= w.pos;
    in_if.velocity_in <= w.vel;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (decay_step(w, r)) filter_out_q.push_back(typed ? typed_res : r);
  endtask

  // loads leave nothing to wait for, so allow the pipeline to empty as well
  task automatic settle();
    in_if.valid <= 1'b0;
    while (filter_out_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= MAX_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: check accepted words, stall in random bursts
  initial begin
    int unsigned hold;
    result_t     got;
    result_t     want;
    hold = 0;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.joint_out, out_if.position_out, out_if.velocity_out, out_if.ok};
        if (filter_out_q.size() == 0) begin
          bad_words++;
          if (bad_words <= 10)
            $display("unexpected result word: joint %0d pos %h vel %h ok %b",
                     got.joint, got.pos, got.vel, got.ok);
        end else begin
          want = filter_out_q.pop_front();
          if (got !== want) begin
            bad_words++;
            if (bad_words <= 10)
              $display("mismatch: exp joint %0d pos %h vel %h ok %b, got %0d %h %h %b",
                       want.joint, want.pos, want.vel, want.ok,
                       got.joint, got.pos, got.vel, got.ok);
          end
        end
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 6);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    word_t             w;
    int                sent;
    int                n;
    q_t                ref_p;
    q_t                ref_v;
    logic [JointW-1:0] jt;
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_if.valid       = 1'b0;
    in_if.opcode      = OP_LOAD;
    in_if.joint       = '0;
    in_if.position_in = '0;
    in_if.velocity_in = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIR; i++) begin
      if (i == DIR_CFG_AT) begin
        settle();
        set_coefs(QOne, '0, '0, QOne, 1'b1);
      end
      push_word(DIR_TAB[i].w, DIR_TAB[i].typed, DIR_TAB[i].res);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph)
        0:       set_coefs(q_t'(62259), q_t'(655), -q_t'(19661), q_t'(58982), 1'b1);
        1:       set_coefs(QMAX, QMAX, QMAX, QMAX, 1'b1);
        2:       set_coefs(QMIN, QMIN, QMIN, QMIN, 1'b1);
        3:       set_coefs('0, '0, '0, '0, 1'b1);
        4:       set_coefs(q_t'(62259), q_t'(655), -q_t'(19661), q_t'(58982), 1'b0);
        default: set_coefs(rand_q(), rand_q(), rand_q(), rand_q(), 1'b1);
      endcase
      calm = (ph == NUM_PHASES - 1);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        jt = pick_joint();
        if ($urandom_range(0, 9) < 6) begin
          // load, then a run of updates on the same joint with drifting reference
          w = '{op: OP_LOAD, joint: jt, pos: rand_q(), vel: rand_q()};
          push_word(w, 1'b0, '0);
          sent++;
          n = $urandom_range(1, 6);
          ref_p = rand_q();
          ref_v = rand_q();
          for (int k = 0; k < n; k++) begin
            w = '{op: OP_UPDATE, joint: jt, pos: ref_p, vel: ref_v};
            push_word(w, 1'b0, '0);
            sent++;
            ref_p = ref_p + q_t'($urandom_range(0, 8192)) - q_t'(4096);
            ref_v = ref_v + q_t'($urandom_range(0, 8192)) - q_t'(4096);
          end
        end else begin
          w = '{op: op_e'($urandom_range(0, 1)), joint: jt, pos: rand_q(), vel: rand_q()};
          push_word(w, 1'b0, '0);
          sent++;
        end
      end
    end

    settle();
    if (bad_words == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
